>>> rtl/core/lvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvc_pkg
// Shared constants and types of the competition step unit.
// ----------------------------------------------------------------------------
package lvc_pkg;

    localparam int SPECIES   = 4;
    localparam int LANES     = 4;
    localparam int NREGS     = 8;
    localparam int BIO_W     = 24;
    localparam int DEV_W     = 16;
    localparam int EXP_TERMS = 10;

    localparam logic [23:0] BIO_MAX = 24'hFFFFFF;
    localparam logic [27:0] LN2_Q28 = 28'd186065280;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [2:0] REG_GROWTH = 3'd0;
    localparam logic [2:0] REG_CAPS   = 3'd1;
    localparam logic [2:0] REG_DEMO   = 3'd2;
    localparam logic [2:0] REG_ENV    = 3'd3;
    localparam logic [2:0] REG_COMP0  = 3'd4;

    typedef struct packed {
        logic start;
        logic go;
        logic clear;
    } lane_ctrl_t;

    typedef struct packed {
        logic ratio_ok;
        logic done;
    } lane_stat_t;

endpackage

>>> rtl/core/lvc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvc_div
// Restoring radix-2 divider, one quotient bit per cycle over a chosen count.
// ----------------------------------------------------------------------------
module lvc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [51:0] dividend,
    input  logic [27:0] divisor,
    input  logic [5:0]  nbits,
    output logic        done,
    output logic [51:0] quot
);

    logic [51:0] work_reg, work_next;
    logic [27:0] rem_reg, rem_next;
    logic [27:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [28:0] trial;
    logic        fits;

    assign trial = {rem_reg, work_reg[51]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = dividend << (6'd52 - nbits);
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? 28'(trial - {1'b0, dsr_reg}) : trial[27:0];
            work_next = {work_reg[50:0], fits};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done   = done_reg;
    assign quot   = work_reg;

endmodule

>>> rtl/core/lvc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvc_lane
// One species lane: capacity ratio, growth rate, noise terms and exponential.
// ----------------------------------------------------------------------------
module lvc_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lvc_pkg::lane_ctrl_t     ctrl,
    input  logic                    active,
    input  logic [1:0]              idx,
    input  logic [23:0]             n,
    input  logic [15:0]             k,
    input  logic [15:0]             rm,
    input  logic [3:0][15:0]        brow,
    input  logic [15:0]             env_sd,
    input  logic [15:0]             demo_sd,
    input  logic [15:0]             env_dev,
    input  logic [15:0]             demo_dev,
    input  logic [3:0][31:0]        ratios,
    output lvc_pkg::lane_stat_t     stat,
    output logic [31:0]             ratio,
    output logic [23:0]             result
);

    localparam logic [4:0] L_IDLE   = 5'd0;
    localparam logic [4:0] L_RDIV   = 5'd1;
    localparam logic [4:0] L_RWAIT  = 5'd2;
    localparam logic [4:0] L_SYNC   = 5'd3;
    localparam logic [4:0] L_DET    = 5'd4;
    localparam logic [4:0] L_INNER  = 5'd5;
    localparam logic [4:0] L_MRATE  = 5'd6;
    localparam logic [4:0] L_MENV   = 5'd7;
    localparam logic [4:0] L_MP     = 5'd8;
    localparam logic [4:0] L_SQRT   = 5'd9;
    localparam logic [4:0] L_SDDIV  = 5'd10;
    localparam logic [4:0] L_SDWAIT = 5'd11;
    localparam logic [4:0] L_CLAMP  = 5'd12;
    localparam logic [4:0] L_QDIV   = 5'd13;
    localparam logic [4:0] L_QWAIT  = 5'd14;
    localparam logic [4:0] L_EMLO   = 5'd15;
    localparam logic [4:0] L_EMHI   = 5'd16;
    localparam logic [4:0] L_EDIV   = 5'd17;
    localparam logic [4:0] L_EWAIT  = 5'd18;
    localparam logic [4:0] L_FMLO   = 5'd19;
    localparam logic [4:0] L_FMHI   = 5'd20;
    localparam logic [4:0] L_FIN    = 5'd21;
    localparam logic [4:0] L_DONE   = 5'd22;
    localparam logic [4:0] L_QFIN   = 5'd23;

    localparam logic signed [59:0] RATE_HI = 60'sd2147483648;
    localparam logic signed [59:0] RATE_LO = -60'sd2147483648;

    logic [4:0]         state_reg, state_next;
    logic [31:0]        ratio_reg, ratio_next;
    logic signed [50:0] acc_reg, acc_next;
    logic [1:0]         j_reg, j_next;
    logic signed [40:0] inner_reg, inner_next;
    logic signed [59:0] rate_reg, rate_next;
    logic               pneg_reg, pneg_next;
    logic [31:0]        pmag_reg, pmag_next;
    logic [39:0]        sqv_reg, sqv_next;
    logic [39:0]        sqres_reg, sqres_next;
    logic [39:0]        sqbit_reg, sqbit_next;
    logic [31:0]        qrem_reg, qrem_next;
    logic [3:0]         qquo_reg, qquo_next;
    logic [1:0]         qstep_reg, qstep_next;
    logic signed [4:0]  q_reg, q_next;
    logic [27:0]        f_reg, f_next;
    logic [28:0]        term_reg, term_next;
    logic [29:0]        e_reg, e_next;
    logic [3:0]         t_reg, t_next;
    logic [56:0]        prod_reg, prod_next;
    logic [23:0]        result_reg, result_next;

    logic               div_start;
    logic [51:0]        div_dvd;
    logic [27:0]        div_dsr;
    logic [5:0]         div_nb;
    logic               div_done;
    logic [51:0]        div_quot;

    logic signed [48:0] bprod;
    logic signed [38:0] det;
    logic signed [56:0] rm_prod;
    logic signed [32:0] env_prod;
    logic signed [32:0] p_prod;
    logic [39:0]        sq_try;
    logic signed [59:0] sd_s;
    logic [31:0]        rate_mag;
    logic [31:0]        lq;
    logic [4:0]         qq;
    logic [42:0]        elo, ehi;
    logic [38:0]        flo, fhi;
    logic [5:0]         sh;
    logic [56:0]        shifted;

    assign bprod    = $signed(brow[j_reg]) * $signed({1'b0, ratios[j_reg]});
    assign det      = acc_reg[50:12];
    assign rm_prod  = $signed(rm) * inner_reg;
    assign env_prod = $signed({1'b0, env_sd}) * $signed(env_dev);
    assign p_prod   = $signed({1'b0, demo_sd}) * $signed(demo_dev);
    assign sq_try   = sqres_reg + sqbit_reg;
    assign sd_s     = $signed({8'b0, div_quot});
    assign rate_mag = rate_reg[59] ? 32'(-rate_reg) : rate_reg[31:0];
    assign lq       = 32'(lvc_pkg::LN2_Q28) << qstep_reg;
    assign qq       = {1'b0, qquo_reg};
    assign elo      = term_reg * f_reg[13:0];
    assign ehi      = term_reg * f_reg[27:14];
    assign flo      = n * e_reg[14:0];
    assign fhi      = n * e_reg[29:15];
    assign sh       = 6'd28 - 6'(q_reg);
    assign shifted  = prod_reg >> sh;

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        div_nb    = 6'd32;
        unique case (state_reg)
            L_RDIV: begin
                div_start = 1'b1;
                div_dvd   = {20'b0, n, 8'b0};
                div_dsr   = {12'b0, k};
                div_nb    = 6'd32;
            end
            L_SDDIV: begin
                div_start = 1'b1;
                div_dvd   = {pmag_reg, 20'b0};
                div_dsr   = {8'b0, sqres_reg[19:0]};
                div_nb    = 6'd52;
            end
            L_EDIV: begin
                div_start = 1'b1;
                div_dvd   = {23'b0, prod_reg[56:28]};
                div_dsr   = {24'b0, t_reg};
                div_nb    = 6'd29;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        ratio_next  = ratio_reg;
        acc_next    = acc_reg;
        j_next      = j_reg;
        inner_next  = inner_reg;
        rate_next   = rate_reg;
        pneg_next   = pneg_reg;
        pmag_next   = pmag_reg;
        sqv_next    = sqv_reg;
        sqres_next  = sqres_reg;
        sqbit_next  = sqbit_reg;
        qrem_next   = qrem_reg;
        qquo_next   = qquo_reg;
        qstep_next  = qstep_reg;
        q_next      = q_reg;
        f_next      = f_reg;
        term_next   = term_reg;
        e_next      = e_reg;
        t_next      = t_reg;
        prod_next   = prod_reg;
        result_next = result_reg;
        unique case (state_reg)
            L_IDLE: begin
                if (ctrl.start) begin
                    ratio_next = '0;
                    state_next = (active && (k != 16'd0)) ? L_RDIV : L_SYNC;
                end
            end
            L_RDIV: state_next = L_RWAIT;
            L_RWAIT: begin
                if (div_done) begin
                    ratio_next = div_quot[31:0];
                    state_next = L_SYNC;
                end
            end
            L_SYNC: begin
                if (ctrl.go) begin
                    if (active && (n != 24'd0) && (k != 16'd0)) begin
                        acc_next   = '0;
                        j_next     = '0;
                        state_next = L_DET;
                    end else begin
                        result_next = '0;
                        state_next  = L_DONE;
                    end
                end
            end
            L_DET: begin
                if (j_reg != idx) begin
                    acc_next = acc_reg + 51'(bprod);
                end
                j_next = j_reg + 2'd1;
                if (j_reg == 2'(lvc_pkg::LANES - 1)) begin
                    state_next = L_INNER;
                end
            end
            L_INNER: begin
                inner_next = 41'sd65536 - $signed({9'b0, ratio_reg}) - 41'(det);
                state_next = L_MRATE;
            end
            L_MRATE: begin
                rate_next  = 60'(rm_prod);
                state_next = L_MENV;
            end
            L_MENV: begin
                rate_next  = rate_reg + 60'(env_prod);
                state_next = L_MP;
            end
            L_MP: begin
                pneg_next  = p_prod[32];
                pmag_next  = p_prod[32] ? 32'(-p_prod) : p_prod[31:0];
                sqv_next   = {n, 16'b0};
                sqres_next = '0;
                sqbit_next = 40'd1 << 38;
                state_next = L_SQRT;
            end
            L_SQRT: begin
                if (sqv_reg >= sq_try) begin
                    sqv_next   = sqv_reg - sq_try;
                    sqres_next = (sqres_reg >> 1) + sqbit_reg;
                end else begin
                    sqres_next = sqres_reg >> 1;
                end
                sqbit_next = sqbit_reg >> 2;
                if (sqbit_reg == 40'd1) begin
                    state_next = L_SDDIV;
                end
            end
            L_SDDIV: state_next = L_SDWAIT;
            L_SDWAIT: begin
                if (div_done) begin
                    rate_next  = pneg_reg ? (rate_reg - sd_s) : (rate_reg + sd_s);
                    state_next = L_CLAMP;
                end
            end
            L_CLAMP: begin
                if (rate_reg > RATE_HI) begin
                    rate_next = RATE_HI;
                end else if (rate_reg < RATE_LO) begin
                    rate_next = RATE_LO;
                end
                state_next = L_QDIV;
            end
            L_QDIV: begin
                qrem_next  = rate_mag;
                qquo_next  = '0;
                qstep_next = 2'd3;
                state_next = L_QWAIT;
            end
            L_QWAIT: begin
                if (qrem_reg >= lq) begin
                    qrem_next = qrem_reg - lq;
                    qquo_next = {qquo_reg[2:0], 1'b1};
                end else begin
                    qquo_next = {qquo_reg[2:0], 1'b0};
                end
                qstep_next = qstep_reg - 2'd1;
                if (qstep_reg == 2'd0) begin
                    state_next = L_QFIN;
                end
            end
            L_QFIN: begin
                if (!rate_reg[59]) begin
                    q_next = $signed(qq);
                    f_next = qrem_reg[27:0];
                end else if (qrem_reg == 32'd0) begin
                    q_next = -$signed(qq);
                    f_next = '0;
                end else begin
                    q_next = -$signed(qq) - 5'sd1;
                    f_next = lvc_pkg::LN2_Q28 - qrem_reg[27:0];
                end
                term_next  = 29'd1 << 28;
                e_next     = 30'd1 << 28;
                t_next     = 4'd1;
                state_next = L_EMLO;
            end
            L_EMLO: begin
                prod_next  = 57'(elo);
                state_next = L_EMHI;
            end
            L_EMHI: begin
                prod_next  = prod_reg + 57'({ehi, 14'b0});
                state_next = L_EDIV;
            end
            L_EDIV: state_next = L_EWAIT;
            L_EWAIT: begin
                if (div_done) begin
                    term_next = div_quot[28:0];
                    e_next    = e_reg + 30'(div_quot[28:0]);
                    if (t_reg == 4'(lvc_pkg::EXP_TERMS)) begin
                        state_next = L_FMLO;
                    end else begin
                        t_next     = t_reg + 4'd1;
                        state_next = L_EMLO;
                    end
                end
            end
            L_FMLO: begin
                prod_next  = 57'(flo);
                state_next = L_FMHI;
            end
            L_FMHI: begin
                prod_next  = prod_reg + 57'({fhi, 15'b0});
                state_next = L_FIN;
            end
            L_FIN: begin
                result_next = (shifted > 57'(lvc_pkg::BIO_MAX)) ? lvc_pkg::BIO_MAX
                                                                 : shifted[23:0];
                state_next  = L_DONE;
            end
            L_DONE: begin
                if (ctrl.clear) begin
                    state_next = L_IDLE;
                end
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ratio_reg  <= ratio_next;
        acc_reg    <= acc_next;
        j_reg      <= j_next;
        inner_reg  <= inner_next;
        rate_reg   <= rate_next;
        pneg_reg   <= pneg_next;
        pmag_reg   <= pmag_next;
        sqv_reg    <= sqv_next;
        sqres_reg  <= sqres_next;
        sqbit_reg  <= sqbit_next;
        qrem_reg   <= qrem_next;
        qquo_reg   <= qquo_next;
        qstep_reg  <= qstep_next;
        q_reg      <= q_next;
        f_reg      <= f_next;
        term_reg   <= term_next;
        e_reg      <= e_next;
        t_reg      <= t_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    lvc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .nbits    (div_nb),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign stat.ratio_ok = (state_reg == L_SYNC);
    assign stat.done     = (state_reg == L_DONE);
    assign ratio         = ratio_reg;
    assign result        = result_reg;

endmodule

>>> rtl/core/lotka_volterra_competition_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotka_volterra_competition_step_unit
// Stochastic competition step over four species lanes with a merge stage.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         load or step word
// m_*       out        four new biomasses after a step word
// cfg_*     in         register writes, index and 64-bit data
//
// A load word is written to the biomass store when taken. A step word's length
// is set by the lane divider: ten serial divisions for the exponential series
// plus the ratio and noise divisions, each one bit per cycle, and a serial root.
// Reset clears the registers, the biomass store and the output valid flag.
// A finished result waits in the output register; the next step word is
// accepted meanwhile, and it stalls at its end only if that word is untaken.
// ----------------------------------------------------------------------------
module lotka_volterra_competition_step_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // init_biomass, demo_dev0..3, env_dev0..3
    input  logic [2:0]   s_tuser,   // op, species
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // biomass0, biomass1, biomass2, biomass3
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_RATIO = 2'd1;
    localparam logic [1:0] T_RUN   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [7:0][63:0]  cfg_reg;
    logic [3:0][23:0]  store_reg;
    logic [3:0][15:0]  demo_reg, env_reg;
    logic [95:0]       mdata_reg;
    logic              mvalid_reg;

    lvc_pkg::lane_ctrl_t       ctrl;
    lvc_pkg::lane_stat_t [3:0] stat;
    logic [3:0][31:0]          ratio_all;
    logic [3:0][23:0]          result_all;
    logic [3:0]                all_ok, all_done;
    logic                      accept, load_out;

    assign s_tready  = (state_reg == T_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < lvc_pkg::LANES; i++) begin
            all_ok[i]   = stat[i].ratio_ok;
            all_done[i] = stat[i].done;
        end
    end

    assign ctrl.start = accept && (s_tuser[0] == lvc_pkg::OP_STEP);
    assign ctrl.go    = (state_reg == T_RATIO) && (&all_ok);
    assign load_out   = (state_reg == T_RUN) && (&all_done) && !mvalid_reg;
    assign ctrl.clear = load_out;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:  if (ctrl.start) state_next = T_RATIO;
            T_RATIO: if (ctrl.go) state_next = T_RUN;
            T_RUN:   if (load_out) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_IDLE;
            cfg_reg    <= '0;
            store_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && (cfg_addr < 4'(lvc_pkg::NREGS))) begin
                cfg_reg[cfg_addr[2:0]] <= cfg_wdata;
            end
            if (accept && (s_tuser[0] == lvc_pkg::OP_LOAD)
                && ({1'b0, s_tuser[2:1]} < 3'(lvc_pkg::SPECIES))) begin
                store_reg[s_tuser[2:1]] <= s_tdata[23:0];
            end
            if (load_out) begin
                store_reg  <= result_all;
                mvalid_reg <= 1'b1;
            end else if (m_tready && mvalid_reg) begin
                mvalid_reg <= 1'b0;
            end
        end
        if (ctrl.start) begin
            for (int i = 0; i < lvc_pkg::LANES; i++) begin
                demo_reg[i] <= s_tdata[24 + 16 * i +: 16];
                env_reg[i]  <= s_tdata[88 + 16 * i +: 16];
            end
        end
        if (load_out) begin
            mdata_reg <= result_all;
        end
    end

    for (genvar g = 0; g < lvc_pkg::LANES; g++) begin : g_lane
        lvc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .active   (g < lvc_pkg::SPECIES),
            .idx      (2'(g)),
            .n        (store_reg[g]),
            .k        (cfg_reg[lvc_pkg::REG_CAPS][16 * g +: 16]),
            .rm       (cfg_reg[lvc_pkg::REG_GROWTH][16 * g +: 16]),
            .brow     (cfg_reg[lvc_pkg::REG_COMP0 + 3'(g)]),
            .env_sd   (cfg_reg[lvc_pkg::REG_ENV][16 * g +: 16]),
            .demo_sd  (cfg_reg[lvc_pkg::REG_DEMO][16 * g +: 16]),
            .env_dev  (env_reg[g]),
            .demo_dev (demo_reg[g]),
            .ratios   (ratio_all),
            .stat     (stat[g]),
            .ratio    (ratio_all[g]),
            .result   (result_all[g])
        );
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

`ifndef SYNTHESIS
    a_idle_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_IDLE) |-> !(|all_done))
        else $error("lane reports done while the unit is idle");

    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !mvalid_reg)
        else $error("result loaded over an untaken word");

    a_valid_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == T_RUN))
        else $error("output word raised outside the end of a step");

    a_go_after_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.go |=> (state_reg == T_RUN))
        else $error("ratio phase release did not enter the run phase");
`endif

endmodule

>>> test/lotka_volterra_competition_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotka_volterra_competition_step_unit_tb
// Self-checking bench for the competition step unit. A directed table covers
// reset state, field extremes, zero capacity and zero biomass, and ignored
// register indexes. Random phases follow, each with its own register setting
// and idling pattern. Step words are checked against a fixed-point predictor
// with its own biomass store and register copy, typed rows against the table.
// ----------------------------------------------------------------------------
module lotka_volterra_competition_step_unit_tb;
    import lvc_pkg::*;

    localparam longint LN2       = 64'sd186065280;
    localparam longint RATE_MAX  = 64'sd2147483648;
    localparam int     SETTLE    = 600;
    localparam longint LIMIT     = 3000000;

    typedef enum int {ROW_CFG, ROW_LOAD, ROW_STEP} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [3:0]   addr;
        logic [63:0]  wdata;
        logic [1:0]   species;
        logic [23:0]  biomass;
        logic [127:0] devs;
        bit           typed;
        logic [95:0]  want;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_addr;
    logic [63:0]  cfg_wdata;

    logic [63:0]  model_regs [NREGS];
    logic [23:0]  model_bio [LANES];
    logic [95:0]  pending_biomass [$];
    stim_row_t    directed_rows [$];
    int           fails = 0;
    int           idle_mode = 0;
    longint       cycles = 0;

    lotka_volterra_competition_step_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint lane_signed(logic [63:0] r, int i);
        return longint'($signed(r[16*i +: 16]));
    endfunction

    function automatic longint lane_unsigned(logic [63:0] r, int i);
        return longint'({48'd0, r[16*i +: 16]});
    endfunction

    function automatic longint cap_ratio(int j);
        longint k;
        k = lane_unsigned(model_regs[REG_CAPS], j);
        if (k == 0) return 0;
        return (longint'({40'd0, model_bio[j]}) <<< 8) / k;
    endfunction

    function automatic logic [23:0] grown_biomass(int i, logic signed [15:0] ddev,
                                                  logic signed [15:0] edev);
        longint n, det, inner, rate, p, s, mag, sd, q, f, term, e, res;
        n = longint'({40'd0, model_bio[i]});
        if (n == 0 || lane_unsigned(model_regs[REG_CAPS], i) == 0) return 24'd0;
        det = 0;
        for (int j = 0; j < SPECIES; j++)
            if (j != i) det += lane_signed(model_regs[REG_COMP0 + i], j) * cap_ratio(j);
        det = det >>> 12;
        inner = 65536 - cap_ratio(i) - det;
        rate = lane_signed(model_regs[REG_GROWTH], i) * inner
             + lane_unsigned(model_regs[REG_ENV], i) * longint'(edev);
        p = lane_unsigned(model_regs[REG_DEMO], i) * longint'(ddev);
        s = int_sqrt(n <<< 16);
        mag = (p < 0) ? -p : p;
        sd = (mag <<< 20) / s;
        rate += (p < 0) ? -sd : sd;
        if (rate > RATE_MAX) rate = RATE_MAX;
        if (rate < -RATE_MAX) rate = -RATE_MAX;
        if (rate >= 0) q = rate / LN2;
        else q = -(((-rate) + LN2 - 1) / LN2);
        f = rate - q * LN2;
        term = 64'sd1 <<< 28;
        e = term;
        for (int t = 1; t <= EXP_TERMS; t++) begin
            term = ((term * f) >>> 28) / t;
            e += term;
        end
        res = (n * e) >>> (28 - q);
        return (res > 64'sd16777215) ? BIO_MAX : res[23:0];
    endfunction

    function automatic logic [95:0] step_community(logic [127:0] devs);
        logic [95:0] nxt;
        nxt = '0;
        for (int i = 0; i < SPECIES; i++)
            nxt[24*i +: 24] = grown_biomass(i, devs[16*i +: 16], devs[16*(i+4) +: 16]);
        for (int i = 0; i < LANES; i++) model_bio[i] = nxt[24*i +: 24];
        return nxt;
    endfunction

    // Drain the block before a register write; loads give no result, so a
    // settle pause follows the last step result.
    task automatic write_reg(logic [3:0] addr, logic [63:0] data);
        while (pending_biomass.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        do @(posedge aclk); while (!cfg_ready);
        if (addr < NREGS) model_regs[addr] = data;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_word(logic op, logic [1:0] sp, logic [23:0] bio,
                             logic [127:0] devs, bit typed, logic [95:0] want);
        logic [95:0] nxt;
        while ((idle_mode == 1 && $urandom_range(99) < 74)
               || (idle_mode == 3 && $urandom_range(99) < 33)) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = {sp, op};
        s_tdata  = {devs, bio};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            if (sp < SPECIES) model_bio[sp] = bio;
        end else begin
            nxt = step_community(devs);
            if (typed && nxt != want)
                $display("%0t predictor disagrees with table: expected %h, predicted %h",
                         $time, want, nxt);
            pending_biomass.push_back(typed ? want : nxt);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic add_row(row_kind_t kind, logic [3:0] addr, logic [63:0] wdata,
                           logic [1:0] sp, logic [23:0] bio, logic [127:0] devs,
                           bit typed, logic [95:0] want);
        stim_row_t r;
        r.kind = kind; r.addr = addr; r.wdata = wdata; r.species = sp;
        r.biomass = bio; r.devs = devs; r.typed = typed; r.want = want;
        directed_rows.push_back(r);
    endtask

    function automatic logic [15:0] rand_dev();
        int acc;
        if ($urandom_range(9) == 0) return 16'($urandom);
        acc = 0;
        for (int k = 0; k < 3; k++) acc += $urandom_range(8192) - 4096;
        return 16'(acc);
    endfunction

    function automatic logic [63:0] rand_reg(int style, int idx);
        logic [63:0] v;
        int mag;
        if (style == 1) return {$urandom, $urandom};
        if (style == 2) return ($urandom_range(1) == 0) ? 64'd0 : '1;
        for (int i = 0; i < LANES; i++) begin
            case (idx)
                REG_GROWTH: begin
                    mag = $urandom_range(12288);
                    v[16*i +: 16] = ($urandom_range(4) == 0) ? 16'(-mag) : 16'(mag);
                end
                REG_CAPS: v[16*i +: 16] = ($urandom_range(15) == 0) ? 16'd0
                                          : 16'($urandom_range(4096, 16));
                REG_DEMO: v[16*i +: 16] = 16'($urandom_range(512));
                REG_ENV:  v[16*i +: 16] = 16'($urandom_range(20000));
                default:  v[16*i +: 16] = 16'($urandom_range(6144));
            endcase
        end
        return v;
    endfunction

    always @(negedge aclk) begin
        if ((idle_mode == 2 && $urandom_range(99) < 74)
            || (idle_mode == 3 && $urandom_range(99) < 33))
            m_tready = 1'b0;
        else
            m_tready = aresetn;
    end

    always @(posedge aclk) begin
        logic [95:0] want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("FAIL lotka_volterra_competition_step_unit");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_biomass.size() == 0) begin
                $display("%0t unexpected result word %h", $time, m_tdata);
                fails++;
            end else begin
                want = pending_biomass.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (m_tdata[24*i +: 24] !== want[24*i +: 24]) begin
                        $display("%0t biomass%0d: expected %h, actual %h",
                                 $time, i, want[24*i +: 24], m_tdata[24*i +: 24]);
                        fails++;
                    end
            end
        end
    end

    initial begin
        logic [127:0] d;
        int style;
        int cap;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        for (int i = 0; i < NREGS; i++) model_regs[i] = '0;
        for (int i = 0; i < LANES; i++) model_bio[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(ROW_STEP, 0, 0, 0, 0, '0, 1, '0);
        add_row(ROW_LOAD, 0, 0, 0, 24'hFFFFFF, '0, 0, '0);
        add_row(ROW_LOAD, 0, 0, 1, 24'h000001, '0, 0, '0);
        add_row(ROW_LOAD, 0, 0, 2, 24'h000000, '0, 0, '0);
        add_row(ROW_LOAD, 0, 0, 3, 24'h123456, '0, 0, '0);
        add_row(ROW_STEP, 0, 0, 0, 0, {8{16'h8000}}, 1, '0);
        add_row(ROW_STEP, 0, 0, 0, 0, {8{16'h7FFF}}, 1, '0);
        add_row(ROW_LOAD, 0, 0, 0, 24'hFFFFFF, '0, 0, '0);
        add_row(ROW_LOAD, 0, 0, 1, 24'h000100, '0, 0, '0);
        add_row(ROW_LOAD, 0, 0, 2, 24'h000000, '0, 0, '0);
        add_row(ROW_LOAD, 0, 0, 3, 24'hABCDEF, '0, 0, '0);
        add_row(ROW_CFG, REG_CAPS, '1, 0, 0, '0, 0, '0);
        add_row(ROW_STEP, 0, 0, 0, 0, '0, 1,
                {24'hABCDEF, 24'h000000, 24'h000100, 24'hFFFFFF});
        add_row(ROW_CFG, REG_GROWTH, 64'h7FFF_8000_1000_7FFF, 0, 0, '0, 0, '0);
        add_row(ROW_CFG, REG_DEMO, '1, 0, 0, '0, 0, '0);
        add_row(ROW_CFG, REG_ENV, '1, 0, 0, '0, 0, '0);
        for (int i = 0; i < LANES; i++)
            add_row(ROW_CFG, REG_COMP0 + i, (i % 2) ? 64'h8000_8000_8000_8000
                                                    : 64'h7FFF_7FFF_7FFF_7FFF,
                    0, 0, '0, 0, '0);
        add_row(ROW_CFG, 4'd8, '1, 0, 0, '0, 0, '0);
        add_row(ROW_CFG, 4'd15, 64'h5555_AAAA_5555_AAAA, 0, 0, '0, 0, '0);
        add_row(ROW_STEP, 0, 0, 0, 0, {4{32'h7FFF_8000}}, 0, '0);
        add_row(ROW_LOAD, 0, 0, 2, 24'h000800, '0, 0, '0);
        add_row(ROW_CFG, REG_CAPS, 64'h0100_0000_0001_FFFF, 0, 0, '0, 0, '0);
        add_row(ROW_STEP, 0, 0, 0, 0, {8{16'h8000}}, 0, '0);

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CFG:  write_reg(directed_rows[r].addr, directed_rows[r].wdata);
                ROW_LOAD: send_word(OP_LOAD, directed_rows[r].species,
                                    directed_rows[r].biomass, directed_rows[r].devs, 0, '0);
                default:  send_word(OP_STEP, 0, 0, directed_rows[r].devs,
                                    directed_rows[r].typed, directed_rows[r].want);
            endcase
        end

        for (int ph = 0; ph < 8; ph++) begin
            s_tvalid = 1'b0;
            style = (ph == 7) ? 2 : ph % 3;
            for (int r = 0; r < NREGS; r++) write_reg(4'(r), rand_reg(style, r));
            if (ph == 2) write_reg(4'(NREGS + $urandom_range(7)), {$urandom, $urandom});
            idle_mode = ph % 4;
            for (int sp = 0; sp < LANES; sp++) begin
                cap = lane_unsigned(model_regs[REG_CAPS], sp);
                send_word(OP_LOAD, 2'(sp), 24'($urandom_range(2 * cap + 1) << 8), '0, 0, '0);
            end
            for (int it = 0; it < 121; it++) begin
                for (int k = 0; k < 8; k++) d[16*k +: 16] = rand_dev();
                if ($urandom_range(9) < 3) begin
                    cap = lane_unsigned(model_regs[REG_CAPS], it % LANES);
                    send_word(OP_LOAD, 2'($urandom),
                              ($urandom_range(4) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(2 * cap + 1) << 8),
                              d, 0, '0);
                end else begin
                    send_word(OP_STEP, 2'($urandom), 24'($urandom), d, 0, '0);
                end
            end
        end
        s_tvalid = 1'b0;

        while (pending_biomass.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fails == 0 && pending_biomass.size() == 0) begin
            $display("PASS lotka_volterra_competition_step_unit");
        end else begin
            $display("FAIL lotka_volterra_competition_step_unit");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lvc_pkg.sv
rtl/core/lvc_div.sv
rtl/core/lvc_lane.sv
rtl/core/lotka_volterra_competition_step_unit.sv
test/lotka_volterra_competition_step_unit_tb.sv
